@@ hdl/mcnm_pkg.sv @@
// Package for the MIDI control-change to note mapper.
// Holds controller ranges, register codes and the result beat type.
// No dependencies; used by mcnm_map and midi_control_to_note_mapper.
package mcnm_pkg;

    localparam int STRIPS_DEF = 8;

    localparam logic [6:0] VEL_BASE        = 7'd16;
    localparam logic [6:0] ROW0_BASE       = 7'd32;
    localparam logic [6:0] ROW1_BASE       = 7'd48;
    localparam logic [6:0] ROW2_BASE       = 7'd64;
    localparam logic [6:0] BASE_NOTE_RESET = 7'd60;

    localparam logic REG_BASE_NOTE   = 1'b0;
    localparam logic REG_OUT_CHANNEL = 1'b1;

    localparam logic EV_NOTE_OFF = 1'b0;
    localparam logic EV_NOTE_ON  = 1'b1;

    typedef struct packed {
        logic       event_kind;
        logic [3:0] channel;
        logic [6:0] note_number;
        logic [6:0] velocity;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        logic       vel_we;
        logic       held_we;
    } map_ctl_t;

endpackage

@@ hdl/mcnm_map.sv @@
// Combinational mapping of one control-change beat to up to two note beats.
// Depends on mcnm_pkg; reads the strip velocity and held-note stores.
module mcnm_map
    import mcnm_pkg::*;
#(
    parameter int STRIPS = STRIPS_DEF,
    parameter int SW     = (STRIPS > 1) ? $clog2(STRIPS) : 1
)
(
    input  logic                   is_controller,
    input  logic [6:0]             controller_number,
    input  logic [6:0]             controller_value,
    input  logic [6:0]             base_note,
    input  logic [3:0]             out_channel,
    input  logic [STRIPS-1:0][6:0] strip_vel,
    input  logic [STRIPS-1:0][6:0] held_note,
    output map_ctl_t               ctl,
    output logic [SW-1:0]          strip,
    output result_t                res0,
    output result_t                res1
);

    localparam logic [6:0] STRIPS_N = 7'(STRIPS);

    logic          is_slider;
    logic          is_vel;
    logic          is_row0;
    logic          is_row1;
    logic          is_row2;
    logic          zero_val;
    logic [6:0]    offset;
    logic [1:0]    row;
    logic [6:0]    button_note;
    logic [6:0]    vel_k;
    logic [6:0]    held_k;

    assign is_slider = controller_number < STRIPS_N;
    assign is_vel    = (controller_number >= VEL_BASE)
                    && (controller_number < VEL_BASE + STRIPS_N);
    assign is_row0   = (controller_number >= ROW0_BASE)
                    && (controller_number < ROW0_BASE + STRIPS_N);
    assign is_row1   = (controller_number >= ROW1_BASE)
                    && (controller_number < ROW1_BASE + STRIPS_N);
    assign is_row2   = (controller_number >= ROW2_BASE)
                    && (controller_number < ROW2_BASE + STRIPS_N);
    assign zero_val  = controller_value == 7'd0;

    always_comb
    begin
        offset = controller_number;
        row    = 2'd0;
        if (is_vel)
        begin
            offset = controller_number - VEL_BASE;
        end
        else if (is_row0)
        begin
            offset = controller_number - ROW0_BASE;
        end
        else if (is_row1)
        begin
            offset = controller_number - ROW1_BASE;
            row    = 2'd1;
        end
        else if (is_row2)
        begin
            offset = controller_number - ROW2_BASE;
            row    = 2'd2;
        end
    end

    assign strip  = offset[SW-1:0];
    assign vel_k  = strip_vel[strip];
    assign held_k = held_note[strip];

    assign button_note = base_note + 7'(3 * 32'(strip)) + 7'(row);

    always_comb
    begin
        ctl  = '0;
        res0 = '0;
        res1 = '0;
        res0.channel = out_channel;
        res1.channel = out_channel;
        if (is_controller)
        begin
            if (is_slider)
            begin
                ctl.held_we       = 1'b1;
                ctl.count         = zero_val ? 2'd1 : 2'd2;
                res0.event_kind   = EV_NOTE_OFF;
                res0.note_number  = held_k;
                res0.velocity     = 7'd0;
                res0.last_of_run  = zero_val;
                res1.event_kind   = EV_NOTE_ON;
                res1.note_number  = controller_value;
                res1.velocity     = vel_k;
                res1.last_of_run  = 1'b1;
            end
            else if (is_vel)
            begin
                ctl.vel_we = 1'b1;
            end
            else if (is_row0 || is_row1 || is_row2)
            begin
                ctl.count         = 2'd1;
                res0.event_kind   = zero_val ? EV_NOTE_OFF : EV_NOTE_ON;
                res0.note_number  = button_note;
                res0.velocity     = zero_val ? 7'd0 : vel_k;
                res0.last_of_run  = 1'b1;
            end
        end
    end

endmodule

@@ hdl/midi_control_to_note_mapper.sv @@
// Top level of the MIDI control-change to note mapper: input stage, strip
// stores, two-entry result queue and APB registers. Depends on mcnm_pkg, mcnm_map.
//
//   channel  | handshake                  | beat
//   ---------+----------------------------+------------------------------------
//   item     | item_valid / item_stall    | is_controller, controller_number,
//            |                            | controller_value
//   result   | result_valid / result_stall| event_kind, channel, note_number,
//            |                            | velocity, last_of_run
//   config   | APB psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// An item beat is registered, then mapped in one pass and pushed into the
// result queue. Velocity controls sustain one item per cycle; buttons do so
// while the result side is not stalled. A slider item with a non-zero value
// gives two result beats, sent one after the other by the single result port.
// Reset clears the stores, the queue and the channel and sets the base note
// to 60. A stalled result side fills the queue and then stalls the item side.
module midi_control_to_note_mapper
    import mcnm_pkg::*;
#(
    parameter int STRIPS = STRIPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        is_controller,
    input  logic [6:0]  controller_number,
    input  logic [6:0]  controller_value,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        event_kind,
    output logic [3:0]  channel,
    output logic [6:0]  note_number,
    output logic [6:0]  velocity,
    output logic        last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = (STRIPS > 1) ? $clog2(STRIPS) : 1;

    logic [6:0]             base_note_reg;
    logic [3:0]             out_channel_reg;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_ctl_reg;
    logic [6:0]             s1_num_reg;
    logic [6:0]             s1_val_reg;
    logic [STRIPS-1:0][6:0] vel_reg;
    logic [STRIPS-1:0][6:0] vel_next;
    logic [STRIPS-1:0][6:0] held_reg;
    logic [STRIPS-1:0][6:0] held_next;
    result_t [1:0]          q_reg;
    result_t [1:0]          q_next;
    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;

    map_ctl_t      map_ctl;
    logic [SW-1:0] map_strip;
    result_t       res0;
    result_t       res1;
    logic          accept;
    logic          pop;
    logic          advance;
    logic [1:0]    room;
    logic          cfg_write;

    mcnm_map #(
        .STRIPS (STRIPS),
        .SW     (SW)
    ) u_map (
        .is_controller     (s1_ctl_reg),
        .controller_number (s1_num_reg),
        .controller_value  (s1_val_reg),
        .base_note         (base_note_reg),
        .out_channel       (out_channel_reg),
        .strip_vel         (vel_reg),
        .held_note         (held_reg),
        .ctl               (map_ctl),
        .strip             (map_strip),
        .res0              (res0),
        .res1              (res1)
    );

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            REG_BASE_NOTE:   prdata = {25'd0, base_note_reg};
            REG_OUT_CHANNEL: prdata = {28'd0, out_channel_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_note_reg   <= BASE_NOTE_RESET;
            out_channel_reg <= 4'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_BASE_NOTE:   base_note_reg   <= pwdata[6:0];
                REG_OUT_CHANNEL: out_channel_reg <= pwdata[3:0];
                default:         base_note_reg   <= base_note_reg;
            endcase
        end
    end

    // handshake and queue room
    assign result_valid = cnt_reg != 2'd0;
    assign pop          = result_valid && !result_stall;
    assign room         = 2'd2 - cnt_reg + {1'b0, pop};
    assign advance      = s1_valid_reg && (room >= map_ctl.count);
    assign item_stall   = s1_valid_reg && !advance;
    assign accept       = item_valid && !item_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= is_controller;
            s1_num_reg <= controller_number;
            s1_val_reg <= controller_value;
        end
    end

    // strip stores
    always_comb
    begin
        vel_next  = vel_reg;
        held_next = held_reg;
        if (advance && map_ctl.vel_we)
        begin
            vel_next[map_strip] = s1_val_reg;
        end
        if (advance && map_ctl.held_we)
        begin
            held_next[map_strip] = s1_val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            vel_reg  <= vel_next;
            held_reg <= held_next;
        end
    end

    // result queue: pop the head, then append the new beats
    always_comb
    begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            cnt_next  = cnt_reg - 2'd1;
        end
        if (advance)
        begin
            case (map_ctl.count)
                2'd1:
                begin
                    q_next[cnt_next[0]] = res0;
                    cnt_next            = cnt_next + 2'd1;
                end
                2'd2:
                begin
                    q_next[0] = res0;
                    q_next[1] = res1;
                    cnt_next  = cnt_next + 2'd2;
                end
                default:
                begin
                    cnt_next = cnt_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign event_kind  = q_reg[0].event_kind;
    assign channel     = q_reg[0].channel;
    assign note_number = q_reg[0].note_number;
    assign velocity    = q_reg[0].velocity;
    assign last_of_run = q_reg[0].last_of_run;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_pair_room: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && map_ctl.count == 2'd2) |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("two-beat push without room");

    a_first_is_off: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_of_run) |-> (event_kind == EV_NOTE_OFF))
        else $error("leading beat of a pair is not a note off");

    a_off_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && event_kind == EV_NOTE_OFF) |-> (velocity == 7'd0))
        else $error("note off with non-zero velocity");

endmodule
